// ===== src/uav_pkg.sv =====
// shared types and constants for the name atom validator
`default_nettype none

package uav_pkg;

    localparam int MAX_ATOM_BYTES = 256;
    localparam int LEN_W          = 9;
    localparam int CP_W           = 21;
    localparam int SEQ_W          = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 9;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = LEN_W'(MAX_ATOM_BYTES);
    localparam logic [7:0]       SEPARATOR_RESET  = 8'h2e;

    localparam logic [CP_W-1:0] CP_MIN_THREE = CP_W'(24'h000800);
    localparam logic [CP_W-1:0] CP_MIN_FOUR  = CP_W'(24'h010000);
    localparam logic [CP_W-1:0] CP_MAX       = CP_W'(24'h10ffff);
    localparam logic [CP_W-1:0] CP_SURR_LO   = CP_W'(24'h00d800);
    localparam logic [CP_W-1:0] CP_SURR_HI   = CP_W'(24'h00dfff);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LENGTH = 1'b0,
        CFG_SEPARATOR  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_NUL       = 4'd1,
        ERR_BAD_LEAD  = 4'd2,
        ERR_BAD_CONT  = 4'd3,
        ERR_TRUNCATED = 4'd4,
        ERR_OVERLONG  = 4'd5,
        ERR_SURROGATE = 4'd6,
        ERR_TOO_LARGE = 4'd7,
        ERR_SEPARATOR = 4'd8,
        ERR_TOO_LONG  = 4'd9
    } err_code_t;

    typedef struct packed {
        logic             valid_res;
        err_code_t        error_code;
        logic [LEN_W-1:0] byte_count;
    } result_t;

endpackage

`default_nettype wire

// ===== src/uav_if.sv =====
// stream interfaces for atom bytes and check results
`default_nettype none

interface uav_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface uav_res_if;
    logic                     valid;
    logic                     ready;
    logic                     valid_res;
    uav_pkg::err_code_t       error_code;
    logic [uav_pkg::LEN_W-1:0] byte_count;

    modport source (output valid, output valid_res, output error_code, output byte_count,
                    input ready);
    modport sink   (input valid, input valid_res, input error_code, input byte_count,
                    output ready);
endinterface

`default_nettype wire

// ===== src/uav_decoder.sv =====
// per-byte utf-8 decoder, separator and length check with atom state
`default_nettype none

module uav_decoder
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      last,
    input  wire logic [uav_pkg::LEN_W-1:0] limit,
    input  wire logic [7:0]                separator_byte,
    output uav_pkg::result_t               result
);
    import uav_pkg::*;

    logic [SEQ_W-1:0] pend_reg, pend_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0] len_reg, len_next;
    err_code_t        ferr_reg, ferr_next;

    always_comb
    begin
        err_code_t        err;
        logic [SEQ_W-1:0] pend_step;
        logic [SEQ_W-1:0] seq_step;
        logic [CP_W-1:0]  acc_step;
        logic [LEN_W-1:0] len_step;
        err_code_t        ferr_step;

        err       = ERR_NONE;
        pend_step = pend_reg;
        seq_step  = seq_reg;
        acc_step  = acc_reg;

        if (pend_reg != '0)
        begin
            if (data_byte[7:6] != 2'b10)
            begin
                pend_step = '0;
                err       = ERR_BAD_CONT;
            end
            else
            begin
                acc_step  = {acc_reg[CP_W-7:0], data_byte[5:0]};
                pend_step = pend_reg - SEQ_W'(1);
                if (pend_step == '0)
                begin
                    if (seq_reg == SEQ_W'(2) && acc_step < CP_MIN_THREE)
                        err = ERR_OVERLONG;
                    else if (seq_reg == SEQ_W'(3) && acc_step < CP_MIN_FOUR)
                        err = ERR_OVERLONG;
                    else if (acc_step > CP_MAX)
                        err = ERR_TOO_LARGE;
                    else if (acc_step >= CP_SURR_LO && acc_step <= CP_SURR_HI)
                        err = ERR_SURROGATE;
                end
            end
        end
        else if (data_byte == 8'h00)
            err = ERR_NUL;
        else if (data_byte[7] == 1'b0)
            err = ERR_NONE;
        else if (data_byte[7:5] == 3'b110)
        begin
            if (data_byte[4:1] == 4'b0000)
                err = ERR_OVERLONG;
            else
            begin
                pend_step = SEQ_W'(1);
                seq_step  = SEQ_W'(1);
                acc_step  = CP_W'(data_byte[4:0]);
            end
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            pend_step = SEQ_W'(2);
            seq_step  = SEQ_W'(2);
            acc_step  = CP_W'(data_byte[3:0]);
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            pend_step = SEQ_W'(3);
            seq_step  = SEQ_W'(3);
            acc_step  = CP_W'(data_byte[2:0]);
        end
        else
            err = ERR_BAD_LEAD;

        if (err == ERR_NONE && data_byte == separator_byte)
            err = ERR_SEPARATOR;

        len_step = (len_reg <= limit) ? len_reg + LEN_W'(1) : len_reg;
        if (err == ERR_NONE && len_step > limit)
            err = ERR_TOO_LONG;

        ferr_step = (ferr_reg == ERR_NONE) ? err : ferr_reg;
        if (ferr_step == ERR_NONE && pend_step != '0)
            ferr_step = last ? ERR_TRUNCATED : ERR_NONE;

        result.valid_res  = (ferr_step == ERR_NONE);
        result.error_code = ferr_step;
        result.byte_count = len_step;

        if (last)
        begin
            pend_next = '0;
            seq_next  = '0;
            acc_next  = '0;
            len_next  = '0;
            ferr_next = ERR_NONE;
        end
        else
        begin
            pend_next = pend_step;
            seq_next  = seq_step;
            acc_next  = acc_step;
            len_next  = len_step;
            ferr_next = ferr_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            seq_reg  <= '0;
            acc_reg  <= '0;
            len_reg  <= '0;
            ferr_reg <= ERR_NONE;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            seq_reg  <= seq_next;
            acc_reg  <= acc_next;
            len_reg  <= len_next;
            ferr_reg <= ferr_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/uav_out_reg.sv =====
// result register between the decoder and the result channel
`default_nettype none

module uav_out_reg
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire uav_pkg::result_t result,
    output logic                  can_load,
    uav_res_if.source             res
);
    import uav_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load = !valid_reg || res.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign res.valid      = valid_reg;
    assign res.valid_res  = data_reg.valid_res;
    assign res.error_code = data_reg.error_code;
    assign res.byte_count = data_reg.byte_count;

endmodule

`default_nettype wire

// ===== src/utf8_name_atom_validator.sv =====
// top level of the streaming name atom validator
//
//   channel   dir   payload                                  transfer
//   atom      in    data_byte[7:0], last                     valid && ready
//   result    out   valid_res, error_code[3:0], byte_count   valid && ready
//   cfg       in    cfg_index, cfg_data[8:0]                 cfg_we
//
// one byte per cycle while atom is not stalled; the decoder state updates on each transfer
// a result is loaded into the output register at the transfer of its last byte
// and is valid on the result channel from the next cycle
// atom stalls only while a finished result is held and result.ready is low
// reset clears the atom state and the config to max_length 256, separator 0x2e
`default_nettype none

module utf8_name_atom_validator
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [uav_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [uav_pkg::CFG_DATA_W-1:0] cfg_data,
    uav_byte_if.sink                           atom,
    uav_res_if.source                          result
);
    import uav_pkg::*;

    logic [LEN_W-1:0] max_length_reg;
    logic [7:0]       separator_reg;
    logic [LEN_W-1:0] limit;
    logic             can_load;
    logic             accept;
    result_t          step_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
            separator_reg  <= SEPARATOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_LENGTH: max_length_reg <= cfg_data[LEN_W-1:0];
                CFG_SEPARATOR:  separator_reg  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    assign limit = (max_length_reg > MAX_LENGTH_RESET) ? MAX_LENGTH_RESET : max_length_reg;

    assign atom.ready = can_load;
    assign accept     = atom.valid && can_load;

    uav_decoder u_decoder
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (atom.data_byte),
        .last           (atom.last),
        .limit          (limit),
        .separator_byte (separator_reg),
        .result         (step_result)
    );

    uav_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && atom.last),
        .result   (step_result),
        .can_load (can_load),
        .res      (result)
    );

endmodule

`default_nettype wire

// ===== tb/uav_result_checker.sv =====
// transfer monitor, atom verdict predictor and result comparator for the name atom validator
`timescale 1ns / 100ps

module uav_result_checker
    import uav_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    uav_byte_if                   atom,
    uav_res_if                    result,
    output int                    fail_count,
    output int                    outstanding
);

    logic [SEQ_W-1:0] cont_left;
    logic [SEQ_W-1:0] seq_len;
    logic [CP_W-1:0]  cp_acc;
    logic [LEN_W-1:0] len_cnt;
    err_code_t        first_err;
    logic [LEN_W-1:0] max_len;
    logic [7:0]       sep_byte;
    result_t          expected_verdicts[$];

    function automatic err_code_t utf8_decode(input logic [7:0] b);
        if (cont_left != 2'd0)
        begin
            if (b[7:6] != 2'b10)
            begin
                cont_left = 2'd0;
                return ERR_BAD_CONT;
            end
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left != 2'd0)
                return ERR_NONE;
            if (seq_len == 2'd2 && cp_acc < CP_MIN_THREE)
                return ERR_OVERLONG;
            if (seq_len == 2'd3 && cp_acc < CP_MIN_FOUR)
                return ERR_OVERLONG;
            if (cp_acc > CP_MAX)
                return ERR_TOO_LARGE;
            if (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI)
                return ERR_SURROGATE;
            return ERR_NONE;
        end
        if (b == 8'h00)
            return ERR_NUL;
        if (!b[7])
            return ERR_NONE;
        if (b[7:5] == 3'b110)
        begin
            // C0 and C1 can only encode ascii
            if (b[4:1] == 4'd0)
                return ERR_OVERLONG;
            cont_left = 2'd1;
            seq_len   = 2'd1;
            cp_acc    = CP_W'(b[4:0]);
            return ERR_NONE;
        end
        if (b[7:4] == 4'b1110)
        begin
            cont_left = 2'd2;
            seq_len   = 2'd2;
            cp_acc    = CP_W'(b[3:0]);
            return ERR_NONE;
        end
        if (b[7:3] == 5'b11110)
        begin
            cont_left = 2'd3;
            seq_len   = 2'd3;
            cp_acc    = CP_W'(b[2:0]);
            return ERR_NONE;
        end
        return ERR_BAD_LEAD;
    endfunction

    function automatic void clear_atom();
        cont_left = '0;
        seq_len   = '0;
        cp_acc    = '0;
        len_cnt   = '0;
        first_err = ERR_NONE;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic is_last);
        logic [LEN_W-1:0] lim;
        err_code_t        err;
        result_t          verdict;
        lim = (max_len > LEN_W'(MAX_ATOM_BYTES)) ? LEN_W'(MAX_ATOM_BYTES) : max_len;
        err = utf8_decode(b);
        if (err == ERR_NONE && b == sep_byte)
            err = ERR_SEPARATOR;
        if (len_cnt <= lim)
            len_cnt = len_cnt + 1'b1;
        if (err == ERR_NONE && len_cnt > lim)
            err = ERR_TOO_LONG;
        if (first_err == ERR_NONE)
            first_err = err;
        if (is_last)
        begin
            if (first_err == ERR_NONE && cont_left != 2'd0)
                first_err = ERR_TRUNCATED;
            verdict.valid_res  = (first_err == ERR_NONE);
            verdict.error_code = first_err;
            verdict.byte_count = len_cnt;
            expected_verdicts  = {expected_verdicts, verdict};
            clear_atom();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_v;
        if (!rst_n)
        begin
            clear_atom();
            max_len  = MAX_LENGTH_RESET;
            sep_byte = SEPARATOR_RESET;
            expected_verdicts.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_LENGTH)
                    max_len = cfg_data;
                else if (cfg_index == CFG_SEPARATOR)
                    sep_byte = cfg_data[7:0];
            end
            if (atom.valid && atom.ready)
                predict_byte(atom.data_byte, atom.last);
            if (result.valid && result.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transfer: valid_res %0b error_code %0d",
                             $time, result.valid_res, result.error_code);
                    $display("%0t: unexpected result transfer: byte_count %0d",
                             $time, result.byte_count);
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    if (result.valid_res !== exp_v.valid_res)
                    begin
                        fail_count++;
                        $display("%0t: valid_res mismatch: expected %0b actual %0b",
                                 $time, exp_v.valid_res, result.valid_res);
                    end
                    if (result.error_code !== exp_v.error_code)
                    begin
                        fail_count++;
                        $display("%0t: error_code mismatch: expected %0d actual %0d",
                                 $time, exp_v.error_code, result.error_code);
                    end
                    if (result.byte_count !== exp_v.byte_count)
                    begin
                        fail_count++;
                        $display("%0t: byte_count mismatch: expected %0d actual %0d",
                                 $time, exp_v.byte_count, result.byte_count);
                    end
                end
            end
            outstanding = expected_verdicts.size();
        end
    end

endmodule

// ===== tb/tb_utf8_name_atom_validator.sv =====
// stimulus, flow control and verdict for the name atom validator regression
`timescale 1ns / 100ps

module tb_utf8_name_atom_validator;
    import uav_pkg::*;

    typedef enum int {
        FLT_NUL,
        FLT_BAD_LEAD,
        FLT_STRAY_CONT,
        FLT_OVERLONG_TWO,
        FLT_OVERLONG_THREE,
        FLT_OVERLONG_FOUR,
        FLT_SURROGATE,
        FLT_TOO_LARGE,
        FLT_HIGH_LEAD,
        FLT_BAD_CONT,
        FLT_SEPARATOR,
        FLT_TRUNCATE
    } fault_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;

    logic                  byte_taken;
    int                    sent_bytes;
    int                    burst_left;
    int                    holds_asked;
    int                    holds_done;
    logic [LEN_W-1:0]      cur_max;
    logic [7:0]            cur_sep;
    logic [7:0]            atom_bytes[$];

    uav_byte_if atom_ch();
    uav_res_if  res_ch();

    utf8_name_atom_validator i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .atom      (atom_ch),
        .result    (res_ch)
    );

    uav_result_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .atom        (atom_ch),
        .result      (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always
        #6 clk = ~clk;

    // transfer seen at the last rising edge, read back at the falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_taken <= 1'b0;
        else
            byte_taken <= atom_ch.valid && atom_ch.ready;
    end

    function automatic logic [7:0] rnd8(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] rnd_cont();
        return rnd8(8'h80, 8'hbf);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        atom_bytes = {atom_bytes, b};
    endfunction

    task automatic push_cp(input logic [CP_W-1:0] cp);
        if (cp < 21'h80)
            add_byte(cp[7:0]);
        else if (cp < 21'h800)
        begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else
        begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic push_random_cp();
        logic [CP_W-1:0] cp;
        case ($urandom_range(3, 0))
            0: cp = CP_W'($urandom_range(16'h7f, 1));
            1: cp = CP_W'($urandom_range(16'h7ff, 16'h80));
            2: cp = CP_W'($urandom_range(16'hffff, 16'h800));
            default: cp = CP_W'($urandom_range(24'h10ffff, 24'h10000));
        endcase
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
            cp = cp + 21'h800;
        push_cp(cp);
    endtask

    task automatic push_fault(input fault_t kind);
        logic [7:0] b;
        int         n;
        case (kind)
            FLT_NUL:
                add_byte(8'h00);
            FLT_BAD_LEAD:
                add_byte(rnd8(8'hf8, 8'hff));
            FLT_STRAY_CONT:
                add_byte(rnd_cont());
            FLT_OVERLONG_TWO:
            begin
                add_byte(rnd8(8'hc0, 8'hc1));
                add_byte(rnd_cont());
            end
            FLT_OVERLONG_THREE:
            begin
                add_byte(8'he0);
                add_byte(rnd8(8'h80, 8'h9f));
                add_byte(rnd_cont());
            end
            FLT_OVERLONG_FOUR:
            begin
                add_byte(8'hf0);
                add_byte(rnd8(8'h80, 8'h8f));
                add_byte(rnd_cont());
                add_byte(rnd_cont());
            end
            FLT_SURROGATE:
            begin
                add_byte(8'hed);
                add_byte(rnd8(8'ha0, 8'hbf));
                add_byte(rnd_cont());
            end
            FLT_TOO_LARGE:
            begin
                add_byte(8'hf4);
                add_byte(rnd8(8'h90, 8'hbf));
                add_byte(rnd_cont());
                add_byte(rnd_cont());
            end
            FLT_HIGH_LEAD:
            begin
                add_byte(rnd8(8'hf5, 8'hf7));
                repeat (3) add_byte(rnd_cont());
            end
            FLT_BAD_CONT:
            begin
                n = $urandom_range(2, 0);
                if (n == 0)
                    add_byte(rnd8(8'hc2, 8'hdf));
                else if (n == 1)
                    add_byte(rnd8(8'he1, 8'hec));
                else
                    add_byte(rnd8(8'hf1, 8'hf3));
                if (n > 0 && $urandom_range(1, 0) == 1)
                    add_byte(rnd_cont());
                b = rnd8(0, 255);
                while (b[7:6] == 2'b10)
                    b = rnd8(0, 255);
                add_byte(b);
            end
            FLT_SEPARATOR:
                add_byte(cur_sep);
            default:
            begin
                // sequence cut short by the end of the atom
                n = $urandom_range(2, 0);
                if (n == 0)
                    add_byte(rnd8(8'hc2, 8'hdf));
                else if (n == 1)
                    add_byte(rnd8(8'he1, 8'hef));
                else
                    add_byte(rnd8(8'hf1, 8'hf3));
                repeat ($urandom_range(n, 0)) add_byte(rnd_cont());
            end
        endcase
    endtask

    task automatic build_atom();
        int         pick;
        int         n;
        int         pos;
        int         long_pct;
        fault_t     kind;
        logic [7:0] b;
        atom_bytes.delete();
        pick     = $urandom_range(99, 0);
        long_pct = (cur_max <= 40) ? 8 : 1;
        if (pick < 10)
        begin
            repeat ($urandom_range(12, 1)) add_byte(rnd8(0, 255));
        end
        else if (pick < 10 + long_pct)
        begin
            n = int'(cur_max) + $urandom_range(2, 0) - 1;
            if (n < 1)
                n = 1;
            if (n > 270)
                n = $urandom_range(270, 250);
            repeat (n)
            begin
                b = rnd8("a", "z");
                add_byte((b == cur_sep) ? 8'h41 : b);
            end
        end
        else
        begin
            n    = $urandom_range(8, 1);
            pos  = (pick < 45) ? $urandom_range(n - 1, 0) : -1;
            kind = fault_t'($urandom_range(FLT_TRUNCATE, FLT_NUL));
            if (pos >= 0 && kind == FLT_TRUNCATE)
                pos = n;
            for (int i = 0; i <= n; i++)
            begin
                if (i == pos)
                    push_fault(kind);
                if (i < n)
                    push_random_cp();
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(48, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(7, 1);
            if (gap > 0)
            begin
                atom_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        atom_ch.valid     <= 1'b1;
        atom_ch.data_byte <= b;
        atom_ch.last      <= is_last;
        do
            @(negedge clk);
        while (!byte_taken);
        sent_bytes++;
    endtask

    task automatic send_atom();
        for (int i = 0; i < atom_bytes.size(); i++)
            send_byte(atom_bytes[i], i == atom_bytes.size() - 1);
    endtask

    task automatic wait_idle();
        atom_ch.valid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        if (idx == CFG_MAX_LENGTH)
            cur_max = value;
        else
            cur_sep = value[7:0];
    endtask

    task automatic run_random(input int nbytes, input bit with_hold);
        int stop_at;
        stop_at = sent_bytes + nbytes;
        while (sent_bytes < stop_at)
        begin
            build_atom();
            send_atom();
            if (with_hold && holds_asked == holds_done)
            begin
                holds_asked++;
                with_hold = 1'b0;
            end
        end
        wait_idle();
    endtask

    // result side: runs of steady, random and periodic ready, plus long hold-offs
    initial
    begin
        int run_left;
        int mode;
        int period;
        int duty;
        int phase_cnt;
        res_ch.ready = 1'b0;
        run_left   = 0;
        mode       = 0;
        period     = 2;
        duty       = 1;
        phase_cnt  = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                res_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
                holds_done++;
            end
            if (run_left == 0)
            begin
                mode      = $urandom_range(2, 0);
                run_left  = $urandom_range(80, 10);
                period    = $urandom_range(6, 2);
                duty      = $urandom_range(period - 1, 1);
                phase_cnt = 0;
            end
            run_left--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(1, 0));
                default: res_ch.ready <= (phase_cnt % period) < duty;
            endcase
            phase_cnt++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("utf8_name_atom_validator regression: fail");
        $finish;
    end

    initial
    begin
        atom_ch.valid     = 1'b0;
        atom_ch.data_byte = 8'h00;
        atom_ch.last      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_MAX_LENGTH;
        cfg_data          = '0;
        rst_n             = 1'b0;
        sent_bytes        = 0;
        burst_left        = 0;
        holds_asked       = 0;
        cur_max           = MAX_LENGTH_RESET;
        cur_sep           = SEPARATOR_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // decoder corner cases under the reset settings
        atom_bytes = '{8'h41};                      send_atom();
        atom_bytes = '{8'h00};                      send_atom();
        atom_bytes = '{8'hff};                      send_atom();
        atom_bytes = '{8'h80};                      send_atom();
        atom_bytes = '{8'hc1, 8'h80};               send_atom();
        atom_bytes = '{8'he0, 8'h80, 8'h80};        send_atom();
        atom_bytes = '{8'hed, 8'ha0, 8'h80};        send_atom();
        atom_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_atom();
        atom_bytes = '{8'hc3};                      send_atom();
        atom_bytes = '{8'hc3, 8'h00};               send_atom();
        atom_bytes = '{8'h2e};                      send_atom();
        atom_bytes = '{8'h7f, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_atom();
        run_random(500, 1'b1);

        // zero maximum, separator equal to nul
        write_reg(CFG_MAX_LENGTH, 9'd0);
        write_reg(CFG_SEPARATOR, 9'h000);
        run_random(100, 1'b0);

        // separator and too long on the same byte
        write_reg(CFG_MAX_LENGTH, 9'd1);
        write_reg(CFG_SEPARATOR, 9'h041);
        atom_bytes = '{8'h42, 8'h41};
        send_atom();
        run_random(150, 1'b0);

        // maximum above the build limit, separator that is also a stray continuation
        write_reg(CFG_MAX_LENGTH, 9'h1ff);
        write_reg(CFG_SEPARATOR, 9'h080);
        atom_bytes = '{8'h80};
        send_atom();
        atom_bytes.delete();
        repeat (258) add_byte(8'h61);
        send_atom();
        run_random(200, 1'b0);

        write_reg(CFG_MAX_LENGTH, 9'($urandom_range(40, 2)));
        write_reg(CFG_SEPARATOR, 9'($urandom_range(255, 0)));
        run_random(300, 1'b1);

        write_reg(CFG_MAX_LENGTH, MAX_LENGTH_RESET);
        write_reg(CFG_SEPARATOR, {1'b0, SEPARATOR_RESET});
        run_random(250, 1'b0);

        if (fail_count == 0 && outstanding == 0)
            $display("utf8_name_atom_validator regression: pass");
        else
            $display("utf8_name_atom_validator regression: fail");
        $finish;
    end

endmodule
